[hw/rtl/pcfk_pkg.sv]
package pcfk_pkg;

    // 1/K of the cordic in q16
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam int          ATAN_ENTRIES = 30;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CORD = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // arctangent of 2^-i, pi = 2^31
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/planar_chain_forward_kinematics.sv]
// channel   direction  handshake                 payload
// segment   in         i_in_valid / o_in_ready   i_seg_angle, i_seg_length, i_is_last
// end point out        o_out_valid / i_out_ready o_end_x, o_end_y, o_chain_done, o_status
// config    in         psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// a segment is accepted only while idle and passes through a load, one step of
// the shared shift/add rotator per CORDIC step (at most ATAN_ENTRIES), and a
// final step for rounding, joint add and saturation.
// reset is synchronous, active low; origin and joint registers come up at zero.
// a pending end point does not block the next request; the final cycle waits
// only while the output register still holds an end point not taken.
module planar_chain_forward_kinematics
    import pcfk_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_seg_angle,
    input  logic signed [15:0] i_seg_length,
    input  logic               i_is_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic               o_chain_done,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_step;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic r_zero, r_last;
    logic signed [31:0] r_origin_x, r_origin_y, r_joint_x, r_joint_y;
    logic r_open;
    logic r_out_valid;

    logic in_acc, cfg_wr, commit;
    logic [16:0] len_abs;
    logic [32:0] x_mag;
    logic signed [33:0] x_init;
    logic signed [32:0] z_raw, z_init;
    logic fold;
    logic signed [33:0] xs, ys;
    logic signed [32:0] atan_s;
    logic signed [34:0] rx_rnd, ry_rnd;
    logic signed [18:0] dx, dy;
    logic signed [31:0] sx, sy;
    logic signed [33:0] sum_x, sum_y;
    logic sat_x, sat_y;
    logic signed [31:0] ex, ey;

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_wr      = psel && penable && pwrite;
    assign prdata      = paddr[2] ? r_origin_y : r_origin_x;
    assign o_out_valid = r_out_valid;
    assign commit      = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // load: |length| scaled by 1/K, angle folded into +-pi/2
    always_comb begin
        len_abs = i_seg_length[15] ? 17'(-(18'(i_seg_length)))
                                   : 17'(i_seg_length);
        x_mag   = len_abs * INV_GAIN_Q16;
        z_raw   = {i_seg_angle[15], i_seg_angle, 16'b0};
        fold    = 1'b0;
        z_init  = z_raw;
        if (z_raw > 33'sh040000000) begin
            fold   = 1'b1;
            z_init = z_raw - 33'sh080000000;
        end else if (z_raw < -33'sh040000000) begin
            fold   = 1'b1;
            z_init = z_raw + 33'sh080000000;
        end
        x_init = fold ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
    end

    // shared rotator step
    always_comb begin
        xs     = r_x >>> r_step;
        ys     = r_y >>> r_step;
        atan_s = $signed({1'b0, atan_lut(5'(r_step))});
    end

    // rounding, joint add, saturation
    always_comb begin
        rx_rnd = 35'(r_x) + 35'sd32768;
        ry_rnd = 35'(r_y) + 35'sd32768;
        dx     = 19'(rx_rnd >>> 16);
        dy     = 19'(ry_rnd >>> 16);
        sx     = r_open ? r_joint_x : r_origin_x;
        sy     = r_open ? r_joint_y : r_origin_y;
        sum_x  = 34'(sx) + 34'(dx);
        sum_y  = 34'(sy) + 34'(dy);
        sat_x  = (sum_x[33:31] != 3'b000) && (sum_x[33:31] != 3'b111);
        sat_y  = (sum_y[33:31] != 3'b000) && (sum_y[33:31] != 3'b111);
        ex     = sat_x ? (sum_x[33] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum_x[31:0];
        ey     = sat_y ? (sum_y[33] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum_y[31:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_CORD;
            S_CORD: if (r_step == CNT_W'(NSTEP - 1)) n_state = S_FIN;
            S_FIN:  if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_open      <= 1'b0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_joint_x   <= '0;
            r_joint_y   <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[2]) r_origin_y <= pwdata;
                else          r_origin_x <= pwdata;
            end
            if (r_state == S_CORD) r_step <= r_step + 1'b1;
            else                   r_step <= '0;
            if (commit) begin
                r_out_valid <= 1'b1;
                if (!r_zero) begin
                    if (r_last) begin
                        r_joint_x <= r_origin_x;
                        r_joint_y <= r_origin_y;
                        r_open    <= 1'b0;
                    end else begin
                        r_joint_x <= ex;
                        r_joint_y <= ey;
                        r_open    <= 1'b1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x    <= x_init;
            r_y    <= '0;
            r_z    <= z_init;
            r_zero <= (len_abs == 17'd0);
            r_last <= i_is_last;
        end else if (r_state == S_CORD) begin
            if (!r_z[32]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_s;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_s;
            end
        end
        if (commit) begin
            if (r_zero) begin
                o_end_x      <= sx;
                o_end_y      <= sy;
                o_chain_done <= 1'b0;
                o_status     <= ST_ZERO;
            end else begin
                o_end_x      <= ex;
                o_end_y      <= ey;
                o_chain_done <= r_last;
                o_status     <= (sat_x || sat_y) ? ST_SAT : ST_OK;
            end
        end
    end

endmodule

[hw/rtl/pcfk_checker.sv]
module pcfk_checker
    import pcfk_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_end_x,
    input logic               o_chain_done,
    input logic [1:0]         o_status
);

    // a pending end point stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_end_x))
        else $error("end point dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_ZERO || o_status == ST_SAT))
        else $error("unused status code");

    // a rejected segment never closes the chain
    a_zero_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_ZERO |-> !o_chain_done)
        else $error("rejected segment marked as chain end");

    // busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a request");

    // a new end point only comes out of the final busy cycle
    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("end point appeared while idle");

endmodule

bind planar_chain_forward_kinematics pcfk_checker u_pcfk_checker (.*);

[tb/tb_top.sv]
module tb_top
    import pcfk_pkg::*;
;

    localparam int         CORDIC_STEPS  = 16;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam longint     GAIN_Q16      = 39797;
    localparam longint     HALF_PI       = 64'sd1073741824;
    localparam longint     FULL_PI       = 64'sd2147483648;
    localparam longint     COORD_MAX     = 64'sd2147483647;
    localparam longint     COORD_MIN     = -64'sd2147483648;
    localparam logic [2:0] ADDR_ORIGIN_X = 3'd0;
    localparam logic [2:0] ADDR_ORIGIN_Y = 3'd4;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               done;
        logic [1:0]         st;
    } t_end_point;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_seg_angle  = '0;
    logic signed [15:0] i_seg_length = '0;
    logic               i_is_last    = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic signed [31:0] o_end_x;
    logic signed [31:0] o_end_y;
    logic               o_chain_done;
    logic [1:0]         o_status;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [2:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    // kinematics state mirrored in the bench
    longint     base_x, base_y, joint_x, joint_y;
    logic       chain_open;
    t_end_point pending_points[$];
    t_end_point oldest;

    logic       quiet = 1'b0;
    int         out_stall_left = 0;
    int         cycle_count = 0;
    int         errors = 0;
    int         segments_sent = 0;
    int         points_checked = 0;
    int         zero_rejects = 0;
    int         saturations = 0;
    int         chains_closed = 0;
    int         origin_settings = 0;

    planar_chain_forward_kinematics #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_seg_angle  (i_seg_angle),
        .i_seg_length (i_seg_length),
        .i_is_last    (i_is_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_end_x      (o_end_x),
        .o_end_y      (o_end_y),
        .o_chain_done (o_chain_done),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint arctan_step(int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            24: return 64'h00000029;
            25: return 64'h00000014;
            26: return 64'h0000000A;
            27: return 64'h00000005;
            28: return 64'h00000003;
            default: return 64'h00000001;
        endcase
    endfunction

    // works out the end point of one segment and advances the joint
    function automatic void predict_end_point(logic signed [15:0] ang,
                                              logic signed [15:0] len, logic last);
        longint     mag, x, y, z, xs, ys, sx, sy, ex, ey;
        logic       sat;
        t_end_point pt;
        int         i;
        sx  = chain_open ? joint_x : base_x;
        sy  = chain_open ? joint_y : base_y;
        mag = len;
        if (mag < 0) begin
            mag = -mag;
        end
        if (mag == 0) begin
            pt.x    = sx[31:0];
            pt.y    = sy[31:0];
            pt.done = 1'b0;
            pt.st   = ST_ZERO;
            zero_rejects++;
            pending_points.insert(pending_points.size(), pt);
            return;
        end
        x = mag * GAIN_Q16;
        y = 0;
        z = ang;
        z = z * 65536;
        // fold headings beyond a quarter turn into the cordic range
        if (z > HALF_PI) begin
            z = z - FULL_PI;
            x = -x;
        end else if (z < -HALF_PI) begin
            z = z + FULL_PI;
            x = -x;
        end
        for (i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end
        end
        ex  = sx + ((x + 32768) >>> 16);
        ey  = sy + ((y + 32768) >>> 16);
        sat = 1'b0;
        if (ex > COORD_MAX) begin ex = COORD_MAX; sat = 1'b1; end
        if (ex < COORD_MIN) begin ex = COORD_MIN; sat = 1'b1; end
        if (ey > COORD_MAX) begin ey = COORD_MAX; sat = 1'b1; end
        if (ey < COORD_MIN) begin ey = COORD_MIN; sat = 1'b1; end
        pt.x    = ex[31:0];
        pt.y    = ey[31:0];
        pt.done = last;
        pt.st   = sat ? ST_SAT : ST_OK;
        if (sat) begin
            saturations++;
        end
        pending_points.insert(pending_points.size(), pt);
        if (last) begin
            joint_x    = base_x;
            joint_y    = base_y;
            chain_open = 1'b0;
            chains_closed++;
        end else begin
            joint_x    = ex;
            joint_y    = ey;
            chain_open = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [15:0] rand16();
        logic [31:0] u;
        u = $urandom;
        return u[15:0];
    endfunction

    function automatic logic signed [15:0] rand_length();
        int                 r;
        logic signed [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 16'sd0;
        end
        if (r < 30) begin
            v = 16'($urandom_range(1, 16));
            return $urandom_range(0, 1) ? -v : v;
        end
        return rand16();
    endfunction

    // leaves valid high on return; the caller sends again or calls settle
    task automatic send_segment(logic signed [15:0] ang, logic signed [15:0] len, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_seg_angle  <= ang;
        i_seg_length <= len;
        i_is_last    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_end_point(ang, len, last);
        segments_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (CORDIC_STEPS + 4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(logic [2:0] addr, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register at %0d read, expected %h, got %h", $time, addr, want,
                     prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_origin(logic [31:0] ox, logic [31:0] oy);
        settle();
        apb_write(ADDR_ORIGIN_X, ox);
        base_x = longint'($signed(ox));
        apb_write(ADDR_ORIGIN_Y, oy);
        base_y = longint'($signed(oy));
        apb_read(ADDR_ORIGIN_X, ox);
        apb_read(ADDR_ORIGIN_Y, oy);
        origin_settings++;
    endtask

    task automatic test_register_reset();
        settle();
        apb_read(ADDR_ORIGIN_X, 32'd0);
        apb_read(ADDR_ORIGIN_Y, 32'd0);
    endtask

    // quadrant edges and the fold points at +-pi/2 and +-pi
    task automatic test_heading_extremes();
        write_origin(32'd0, 32'd0);
        send_segment(16'sd0,      16'sd32767, 1'b0);
        send_segment(16'sd16384,  16'sd32767, 1'b0);
        send_segment(-16'sd16384, 16'sd32767, 1'b0);
        send_segment(16'sd16385,  16'sd32767, 1'b0);
        send_segment(-16'sd16385, 16'sd32767, 1'b0);
        send_segment(16'sd32767,  16'sd32767, 1'b0);
        send_segment(-16'sd32768, 16'sd32767, 1'b0);
        send_segment(16'sd8192,   16'sd32767, 1'b1);
    endtask

    task automatic test_length_extremes();
        send_segment(16'sd4096,   -16'sd32768, 1'b0);
        send_segment(-16'sd12000, 16'sd32767,  1'b0);
        send_segment(16'sd20000,  16'sd1,      1'b0);
        send_segment(-16'sd30000, -16'sd1,     1'b0);
        send_segment(16'sd100,    16'sd2,      1'b1);
    endtask

    // a zero length is refused and must not close or move the chain
    task automatic test_zero_length();
        write_origin(32'h00012345, 32'hFFFE0001);
        send_segment(16'sd1234,  16'sd0,   1'b0);
        send_segment(16'sd5000,  16'sd700, 1'b0);
        send_segment(-16'sd7000, 16'sd0,   1'b1);
        send_segment(16'sd9000,  -16'sd50, 1'b1);
    endtask

    task automatic test_saturation();
        write_origin(32'h7FFFFF00, 32'h80000010);
        send_segment(16'sd0,      16'sd32767,  1'b0);
        send_segment(-16'sd16384, -16'sd32768, 1'b0);
        send_segment(16'sd32767,  16'sd1000,   1'b1);
        write_origin(32'h80000000, 32'h7FFFFFFF);
        send_segment(-16'sd32768, 16'sd5,      1'b0);
        send_segment(16'sd16384,  16'sd300,    1'b1);
    endtask

    task automatic run_random_chains(int n_items);
        int count, chain_len, k;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                quiet = ~quiet;
            end
            if ($urandom_range(0, 9) == 0) begin
                // stray segment, last mark at random
                send_segment(rand16(), rand16(), 1'($urandom_range(0, 1)));
                count++;
            end else begin
                chain_len = $urandom_range(1, 8);
                for (k = 0; k < chain_len; k++) begin
                    send_segment(rand16(), rand_length(), k == chain_len - 1);
                    count++;
                end
            end
        end
    endtask

    task automatic test_random_chains();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_origin($urandom, $urandom);
                1: write_origin(32'h7FFFFFFF, 32'h80000000);
                2: write_origin(32'h80000000, 32'h7FFFFFFF);
                3: write_origin(32'd0, 32'd0);
                4: write_origin(32'h7FFF0000 + $urandom_range(0, 65535),
                                32'h80010000 - $urandom_range(0, 65535));
                default: write_origin($urandom_range(0, 4095), -$urandom_range(0, 4095));
            endcase
            run_random_chains(105);
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (out_stall_left > 0) begin
            i_out_ready    <= 1'b0;
            out_stall_left <= out_stall_left - 1;
        end else begin
            i_out_ready    <= 1'b1;
            out_stall_left <= pick_gap();
        end
    end

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: end point with no request pending, x %0d y %0d", $time,
                         o_end_x, o_end_y);
                errors++;
            end else begin
                oldest = pending_points.pop_front();
                check_field("end_x", oldest.x, o_end_x);
                check_field("end_y", oldest.y, o_end_y);
                check_field("chain_done", {63'd0, oldest.done}, {63'd0, o_chain_done});
                check_field("status", {62'd0, oldest.st}, {62'd0, o_status});
                points_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d end points outstanding", cycle_count,
                     pending_points.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        base_x     = 0;
        base_y     = 0;
        joint_x    = 0;
        joint_y    = 0;
        chain_open = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_heading_extremes();
        test_length_extremes();
        test_zero_length();
        test_saturation();
        test_random_chains();
        settle();

        $display("run covered %0d segments and %0d end points: %0d zero-length rejects,",
                 segments_sent, points_checked, zero_rejects);
        $display("%0d saturated points, %0d closed chains, %0d origin settings", saturations,
                 chains_closed, origin_settings);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
